// ----- design/cpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the clock page replacement block.
// No dependencies; imported by the controller, the datapath and the top level.
package cpr_pkg;

  // Fixed port widths.
  localparam int CFG_W       = 5;
  localparam int PAGE_IN_W   = 16;
  localparam int INDEX_OUT_W = 4;
  localparam int COUNT_W     = 32;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  // Reset value of the active frame count.
  localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RST = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the page number of an accepted request
    logic lookup;     // resolve a hit or start a miss
    logic sweep_step; // one visit of the clock hand
  } cpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;      // the captured page is resident among the active frames
    logic ref_set;    // the frame under the hand has its reference bit set
  } cpr_status_t;

endpackage

// ----- design/cpr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the clock page replacement block.
// Depends on cpr_pkg for the command and status structs.
module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cpr_status_t status,
  output cpr_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_comb begin
    state_next     = state;
    done_next      = 1'b0;
    cmd.capture    = 1'b0;
    cmd.lookup     = 1'b0;
    cmd.sweep_step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (status.match) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        // A clear reference bit under the hand ends the sweep.
        if (!status.ref_set) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- design/cpr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath for the clock page replacement block: frame table, valid and
// reference bits, clock hand, fault counter and result registers. Uses cpr_pkg.
module cpr_datapath
  import cpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [PAGE_IN_W-1:0]   page_number,
  input  cpr_cmd_t               cmd,
  output cpr_status_t            status,
  output logic                   hit,
  output logic [INDEX_OUT_W-1:0] frame_index,
  output logic [COUNT_W-1:0]     fault_total
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int KW    = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;

  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [MAX_FRAMES-1:0] reference_bit;
  logic [IDX_W-1:0]      hand;
  logic [COUNT_W-1:0]    fault_counter;
  logic [CFG_W-1:0]      active_frames;
  logic [PAGE_BITS-1:0]  page_key;

  logic [NW-1:0]         n_frames;
  logic [NW-1:0]         af_ext;
  logic [MAX_FRAMES-1:0] match_vec;
  logic [IDX_W-1:0]      match_slot;
  logic [IDX_W-1:0]      hand_start;
  logic [IDX_W-1:0]      hand_adv;
  logic [NW-1:0]         hand_inc;
  logic [IDX_W+INDEX_OUT_W-1:0] match_ext;
  logic [IDX_W+INDEX_OUT_W-1:0] hand_ext;

  // Frame count clamped to the range 1 .. MAX_FRAMES.
  always_comb begin
    af_ext = NW'(active_frames);
    if (af_ext == '0) begin
      n_frames = NW'(1);
    end else if (af_ext > NW'(MAX_FRAMES)) begin
      n_frames = NW'(MAX_FRAMES);
    end else begin
      n_frames = af_ext;
    end
  end

  // Parallel compare over the active frames; the lowest match wins.
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match_vec[i] = frame_valid[i] && (frame_page[i] == page_key) &&
                     (NW'(i) < n_frames);
    end
    match_slot = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_slot = IDX_W'(i);
      end
    end
  end

  // A hand left outside the active frames restarts at frame zero.
  assign hand_start = (NW'(hand) >= n_frames) ? '0 : hand;
  assign hand_inc   = NW'(hand) + NW'(1);
  assign hand_adv   = (hand_inc >= n_frames) ? '0 : hand_inc[IDX_W-1:0];

  assign match_ext = {{INDEX_OUT_W{1'b0}}, match_slot};
  assign hand_ext  = {{INDEX_OUT_W{1'b0}}, hand};

  assign status.match   = |match_vec;
  assign status.ref_set = reference_bit[hand];
  assign fault_total    = fault_counter;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      reference_bit <= '0;
      hand          <= '0;
      fault_counter <= '0;
      active_frames <= ACTIVE_FRAMES_RST;
    end else begin
      if (cfg_we) begin
        active_frames <= cfg_data;
      end
      if (cmd.lookup) begin
        if (|match_vec) begin
          reference_bit[match_slot] <= 1'b1;
        end else begin
          if (fault_counter != '1) begin
            fault_counter <= fault_counter + COUNT_W'(1);
          end
          hand <= hand_start;
        end
      end
      if (cmd.sweep_step) begin
        if (reference_bit[hand]) begin
          reference_bit[hand] <= 1'b0;
        end else begin
          frame_valid[hand]   <= 1'b1;
          reference_bit[hand] <= 1'b1;
        end
        hand <= hand_adv;
      end
    end
  end

  // Payload registers: frame table, captured page and result fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_key <= PAGE_BITS'(page_number[KW-1:0]);
    end
    if (cmd.lookup && (|match_vec)) begin
      hit         <= 1'b1;
      frame_index <= match_ext[INDEX_OUT_W-1:0];
    end
    if (cmd.sweep_step && !reference_bit[hand]) begin
      frame_page[hand] <= page_key;
      hit              <= 1'b0;
      frame_index      <= hand_ext[INDEX_OUT_W-1:0];
    end
  end

endmodule

// ----- design/clock_page_replacement.sv -----
`timescale 1ns / 1ps
// A hit is resolved in the lookup state, which registers its result strobe;
// a miss goes on to the sweep state, where the hand clears each set reference
// bit it visits, and the first frame with a clear bit is replaced and ends it.
// A new request is taken in the cycle the strobe is high; the clock sweep
// sets the throughput. Reset empties all frames, clears reference bits, hand
// and fault count and sets active_frames to 16; no clearing pass is needed.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   start,
  input  logic [PAGE_IN_W-1:0]   page_number,
  output logic                   busy,
  output logic                   done,
  output logic                   hit,
  output logic [INDEX_OUT_W-1:0] frame_index,
  output logic [COUNT_W-1:0]     fault_total
);

  cpr_cmd_t    cmd;
  cpr_status_t status;

  cpr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .page_number (page_number),
    .cmd         (cmd),
    .status      (status),
    .hit         (hit),
    .frame_index (frame_index),
    .fault_total (fault_total)
  );

endmodule

// ----- design/cpr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the clock page replacement block, bound to the top level.
// Uses cpr_pkg for the port widths.
module cpr_checker
  import cpr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic                   hit,
  input logic [COUNT_W-1:0]     fault_total
);

  // A request taken always makes the block busy in the next cycle.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after a request was taken");

  // A result strobe ends the work on a request.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without a request in progress");

  // The fault count never goes down.
  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fault_total >= $past(fault_total))
    else $error("fault count decreased");

  // A fault result always carries a non-zero fault count.
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> fault_total != '0)
    else $error("page fault reported with a zero fault count");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .hit         (hit),
  .fault_total (fault_total)
);

// ----- tb/clock_page_replacement_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the clock page replacement block: requests are sent, the
// second-chance outcome of each is predicted in place and compared with every result strobe.
// Depends on cpr_pkg and the clock_page_replacement top level.
module clock_page_replacement_tb;
  import cpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic                   hit;
    logic [INDEX_OUT_W-1:0] frame;
    logic [COUNT_W-1:0]     faults;
  } page_outcome_t;

  logic                   clk;
  logic                   rst         = 1'b1;
  logic                   cfg_we      = 1'b0;
  logic [CFG_W-1:0]       cfg_data    = '0;
  logic                   start       = 1'b0;
  logic [PAGE_IN_W-1:0]   page_number = '0;
  logic                   busy;
  logic                   done;
  logic                   hit;
  logic [INDEX_OUT_W-1:0] frame_index;
  logic [COUNT_W-1:0]     fault_total;

  // Predicted contents of the frame table.
  logic [PAGE_IN_W-1:0] frame_page_q [MAX_FRAMES_DEF];
  bit                   frame_valid_q [MAX_FRAMES_DEF];
  bit                   ref_bit_q [MAX_FRAMES_DEF];
  int                   hand_q;
  logic [COUNT_W-1:0]   faults_q;
  logic [CFG_W-1:0]     frame_count_q;

  page_outcome_t pending_outcomes[$];
  int            mismatch_count;
  int            cycle_count;

  clock_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES_DEF),
    .PAGE_BITS (PAGE_BITS_DEF)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .start      (start),
    .page_number(page_number),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .frame_index(frame_index),
    .fault_total(fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int frames_in_use();
    if (frame_count_q == 0) return 1;
    if (frame_count_q > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
    return frame_count_q;
  endfunction

  // Applies one page reference to the predicted table and returns its outcome.
  function automatic page_outcome_t replace_page(input logic [PAGE_IN_W-1:0] page);
    int n;
    int slot;
    int h;
    int guard;
    bit found;
    page_outcome_t r;
    n = frames_in_use();
    slot = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_valid_q[i] && frame_page_q[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      ref_bit_q[slot] = 1'b1;
    end else begin
      if (faults_q != '1) faults_q = faults_q + 1;
      h = (hand_q >= n) ? 0 : hand_q;
      guard = 0;
      while (guard <= n && ref_bit_q[h]) begin
        ref_bit_q[h] = 1'b0;
        h = (h + 1 >= n) ? 0 : h + 1;
        guard++;
      end
      slot = h;
      frame_page_q[slot] = page;
      frame_valid_q[slot] = 1'b1;
      ref_bit_q[slot] = 1'b1;
      hand_q = (h + 1 >= n) ? 0 : h + 1;
    end
    r.hit = found;
    r.frame = slot[INDEX_OUT_W-1:0];
    r.faults = faults_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    page_outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, hit", hit, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (frame_index !== want.frame) report_mismatch("frame_index", frame_index, want.frame);
        if (fault_total !== want.faults) report_mismatch("fault_total", fault_total, want.faults);
      end
    end
  end

  // Holds the request until it is taken, then records its predicted outcome.
  task automatic send_request(input logic [PAGE_IN_W-1:0] page);
    start <= 1'b1;
    page_number <= page;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(replace_page(page));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_count_q = value;
  endtask

  task automatic test_directed_frames_and_hits();
    set_frame_count(5'd16);
    send_request(16'h0000);
    send_request(16'hFFFF);
    send_request(16'h0000);
    send_request(16'hFFFF);
    // Three frames: the sweep has to clear set bits and wrap round.
    set_frame_count(5'd3);
    send_request(16'h0001);
    send_request(16'h0002);
    send_request(16'h0003);
    // A count of zero behaves as a single frame.
    set_frame_count(5'd0);
    send_request(16'h0005);
    send_request(16'h0005);
    send_request(16'h0006);
    // A count above the built frames behaves as the full set.
    set_frame_count(5'd31);
    send_request(16'hFFFF);
    send_request(16'h8000);
    send_request(16'h7FFF);
    for (int i = 0; i < 5; i++) send_request(PAGE_IN_W'(16'h0010 + i));
    // Shrinking leaves the hand outside the active frames; the next miss restarts at 0.
    set_frame_count(5'd2);
    send_request(16'h0020);
    send_request(16'h0010);
    // Growing again brings back the outer frames, so 0x0010 is resident twice.
    set_frame_count(5'd16);
    send_request(16'h0010);
    send_request(16'h5555);
    send_request(16'hAAAA);
  endtask

  // Mostly references to a small working set, so that hits and sweeps both occur.
  task automatic run_random_phase(input int idle_pct, input int items, input bit hold_off);
    logic [PAGE_IN_W-1:0] base;
    logic [PAGE_IN_W-1:0] page;
    int span;
    int pct;
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 5))
        0: set_frame_count(5'd1);
        1: set_frame_count(5'd16);
        2: set_frame_count(5'd0);
        3: set_frame_count(5'd31);
        default: set_frame_count(CFG_W'($urandom_range(0, 31)));
      endcase
      base = PAGE_IN_W'($urandom);
      span = frames_in_use() + $urandom_range(0, 4);
      pct = ($urandom_range(0, 3) == 0) ? 0 : idle_pct;
      for (int k = 0; k < 40 && sent < items; k++) begin
        if ($urandom_range(0, 99) < 85) page = PAGE_IN_W'(base + $urandom_range(0, span - 1));
        else page = PAGE_IN_W'($urandom);
        send_request(page);
        sent++;
        if (hold_off && sent % 50 == 0) drain_results();
        else if ($urandom_range(0, 99) < pct) pause_sender($urandom_range(1, 20));
      end
    end
  endtask

  task automatic test_back_to_back();
    run_random_phase(0, 320, 1'b0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(62, 320, 1'b1);
  endtask

  task automatic test_mixed_gaps();
    run_random_phase(27, 310, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
      frame_page_q[i] = '0;
      frame_valid_q[i] = 1'b0;
      ref_bit_q[i] = 1'b0;
    end
    hand_q = 0;
    faults_q = '0;
    frame_count_q = ACTIVE_FRAMES_RST;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames_and_hits();
    test_back_to_back();
    test_sender_gaps();
    test_mixed_gaps();

    drain_results();
    repeat (25) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
